// ===== sv/nts_pkg.sv =====
// shared types and constants for the nearest timestamp search block
package nts_pkg;

  localparam int MaxRecords = 1024;
  localparam int TimeW      = 32;
  localparam int IdxW       = $clog2(MaxRecords);
  localparam int CountW     = $clog2(MaxRecords + 1);

  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqSearch = 1'b1;

  localparam logic StatusFound = 1'b0;
  localparam logic StatusEmpty = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IdxW-1:0]   slot_index;
    logic [TimeW-1:0]  time_value;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [IdxW-1:0]   nearest_index;
    logic [TimeW-1:0]  nearest_time;
    logic [TimeW-1:0]  distance;
    logic              exact_hit;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [TimeW-1:0]  target;
    logic [CountW-1:0] count;
  } search_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_CAND_A,
    ST_CAND_A_CMP,
    ST_CAND_B,
    ST_CAND_B_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== sv/nts_ram.sv =====
// record table memory, one write port and one registered read port
module nts_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [nts_pkg::IdxW-1:0]  wr_addr,
  input  logic [nts_pkg::TimeW-1:0] wr_data,
  input  logic [nts_pkg::IdxW-1:0]  rd_addr,
  output logic [nts_pkg::TimeW-1:0] rd_data
);

  logic [nts_pkg::TimeW-1:0] mem [nts_pkg::MaxRecords];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/nts_absdiff.sv =====
// shared compare and absolute difference unit
module nts_absdiff (
  input  logic [nts_pkg::TimeW-1:0] rec,
  input  logic [nts_pkg::TimeW-1:0] target,
  output logic                      below,
  output logic [nts_pkg::TimeW-1:0] diff
);

  always_comb begin
    below = rec < target;
    diff  = below ? (target - rec) : (rec - target);
  end

endmodule

// ===== sv/nts_search.sv =====
// search sequencer: lower-bound binary search and neighbour check
module nts_search (
  input  logic                      clk,
  input  logic                      rst,
  input  nts_pkg::search_req_t      req,
  output logic                      idle,
  output logic [nts_pkg::IdxW-1:0]  rd_addr,
  input  logic [nts_pkg::TimeW-1:0] rd_data,
  input  logic                      take,
  output logic                      done,
  output nts_pkg::out_item_t        result
);

  nts_pkg::state_t state, state_next;

  logic [nts_pkg::CountW-1:0] lo, hi, lo_next, hi_next, n, mid, cand_a;
  logic [nts_pkg::TimeW-1:0]  target;
  logic [nts_pkg::IdxW-1:0]   best_idx;
  logic [nts_pkg::TimeW-1:0]  best_val, best_dist;
  logic                       empty;
  logic                       two_cand;
  logic                       below;
  logic [nts_pkg::TimeW-1:0]  diff;

  nts_absdiff u_absdiff (
    .rec    (rd_data),
    .target (target),
    .below  (below),
    .diff   (diff)
  );

  always_comb begin
    mid      = lo + ((hi - lo) >> 1);
    two_cand = (lo < n) && (lo != '0);
    if (lo >= n) begin
      cand_a = n - 1'b1;
    end else if (lo == '0) begin
      cand_a = '0;
    end else begin
      cand_a = lo - 1'b1;
    end
    lo_next = lo;
    hi_next = hi;
    if (below) begin
      lo_next = mid + 1'b1;
    end else begin
      hi_next = mid;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nts_pkg::ST_IDLE: begin
        if (req.start) begin
          state_next = (req.count == '0) ? nts_pkg::ST_DONE : nts_pkg::ST_PROBE;
        end
      end
      nts_pkg::ST_PROBE:      state_next = nts_pkg::ST_CMP;
      nts_pkg::ST_CMP: begin
        state_next = (lo_next < hi_next) ? nts_pkg::ST_PROBE : nts_pkg::ST_CAND_A;
      end
      nts_pkg::ST_CAND_A:     state_next = nts_pkg::ST_CAND_A_CMP;
      nts_pkg::ST_CAND_A_CMP: state_next = two_cand ? nts_pkg::ST_CAND_B : nts_pkg::ST_DONE;
      nts_pkg::ST_CAND_B:     state_next = nts_pkg::ST_CAND_B_CMP;
      nts_pkg::ST_CAND_B_CMP: state_next = nts_pkg::ST_DONE;
      nts_pkg::ST_DONE: begin
        if (take) begin
          state_next = nts_pkg::ST_IDLE;
        end
      end
      default:                state_next = nts_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle    = 1'b0;
    done    = 1'b0;
    rd_addr = '0;
    case (state)
      nts_pkg::ST_IDLE:   idle    = 1'b1;
      nts_pkg::ST_PROBE:  rd_addr = mid[nts_pkg::IdxW-1:0];
      nts_pkg::ST_CAND_A: rd_addr = cand_a[nts_pkg::IdxW-1:0];
      nts_pkg::ST_CAND_B: rd_addr = lo[nts_pkg::IdxW-1:0];
      nts_pkg::ST_DONE:   done    = 1'b1;
      default:            idle    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      nts_pkg::ST_IDLE: begin
        if (req.start) begin
          target    <= req.target;
          n         <= req.count;
          lo        <= '0;
          hi        <= req.count;
          empty     <= (req.count == '0);
          best_idx  <= '0;
          best_val  <= '0;
          best_dist <= '0;
        end
      end
      nts_pkg::ST_CMP: begin
        lo <= lo_next;
        hi <= hi_next;
      end
      nts_pkg::ST_CAND_A_CMP: begin
        best_idx  <= cand_a[nts_pkg::IdxW-1:0];
        best_val  <= rd_data;
        best_dist <= diff;
      end
      nts_pkg::ST_CAND_B_CMP: begin
        if (diff < best_dist) begin
          best_idx  <= lo[nts_pkg::IdxW-1:0];
          best_val  <= rd_data;
          best_dist <= diff;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.status        = empty ? nts_pkg::StatusEmpty : nts_pkg::StatusFound;
    result.nearest_index = best_idx;
    result.nearest_time  = best_val;
    result.distance      = best_dist;
    result.exact_hit     = !empty && (best_dist == '0);
  end

endmodule

// ===== sv/nearest_timestamp_search_core.sv =====
// top level of the nearest timestamp search block
//
// req channel (req_valid, req_stall, req_data) carries write and search items;
// res channel (res_valid, res_stall, res_data) returns one result per search.
// cfg_wr_en with cfg_wr_data sets record_count, the number of slots in use.
// A write item is stored in the record memory at the transfer edge and
// gives no result. A search runs a lower-bound binary search, each probe
// a read state and then a compare state because the memory read is
// registered, then reads one or two neighbours of the final position the
// same way. A search on an empty table goes straight to its done state.
// The single memory read port sets the pace of a search.
// req_stall is high while a search is in flight. A finished result sits in the
// output register; while res_stall holds it there one more search (and any
// number of write items) can be taken, and a search then waits in its done
// state with req_stall high.
// Reset clears record_count and all control state; memory contents are
// undefined until written.
module nearest_timestamp_search_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [nts_pkg::CountW-1:0]  cfg_wr_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  nts_pkg::in_item_t           req_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output nts_pkg::out_item_t          res_data
);

  logic [nts_pkg::CountW-1:0] record_count;
  logic [nts_pkg::CountW-1:0] count_used;
  logic                       req_xfer;
  logic                       srch_idle;
  logic                       srch_done;
  logic                       res_take;
  nts_pkg::search_req_t       srch_req;
  nts_pkg::out_item_t         srch_result;
  logic [nts_pkg::IdxW-1:0]   rd_addr;
  logic [nts_pkg::TimeW-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= '0;
    end else if (cfg_wr_en) begin
      record_count <= cfg_wr_data;
    end
  end

  always_comb begin
    count_used = (record_count > nts_pkg::CountW'(nts_pkg::MaxRecords))
               ? nts_pkg::CountW'(nts_pkg::MaxRecords) : record_count;
    req_stall  = !srch_idle;
    req_xfer   = req_valid && !req_stall;
    res_take   = !res_valid || !res_stall;
    srch_req.start  = req_xfer && (req_data.req_type == nts_pkg::ReqSearch);
    srch_req.target = req_data.time_value;
    srch_req.count  = count_used;
  end

  nts_ram u_ram (
    .clk     (clk),
    .wr_en   (req_xfer && (req_data.req_type == nts_pkg::ReqWrite)),
    .wr_addr (req_data.slot_index),
    .wr_data (req_data.time_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nts_search u_search (
    .clk     (clk),
    .rst     (rst),
    .req     (srch_req),
    .idle    (srch_idle),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .take    (res_take),
    .done    (srch_done),
    .result  (srch_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= srch_done;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && srch_done) begin
      res_data <= srch_result;
    end
  end

endmodule

// ===== tb/sv/tb_nearest_timestamp_search_core.sv =====
// self-checking testbench for the nearest timestamp search core
module tb_nearest_timestamp_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [nts_pkg::CountW-1:0] cfg_wr_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  nts_pkg::in_item_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  nts_pkg::out_item_t res_data;

  // stimulus side
  nts_pkg::in_item_t pending_reqs[$];
  logic [nts_pkg::TimeW-1:0] gen_table [nts_pkg::MaxRecords];
  bit gen_written [nts_pkg::MaxRecords];
  int filled = 0;
  int table_len = 0;
  int reqs_queued = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // prediction side
  logic [nts_pkg::TimeW-1:0] rec_mem [nts_pkg::MaxRecords];
  logic [nts_pkg::CountW-1:0] rec_count = '0;
  nts_pkg::out_item_t expected_nearest[$];
  int reqs_taken_cnt = 0;
  logic req_taken = 1'b0;
  int fail_count = 0;

  nearest_timestamp_search_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data)
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [nts_pkg::TimeW-1:0] abs_gap(
    input logic [nts_pkg::TimeW-1:0] a, b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic nts_pkg::out_item_t nearest_of(input logic [nts_pkg::TimeW-1:0] target);
    nts_pkg::out_item_t r;
    int n, lo, hi, mid, best;
    r = '0;
    n = (rec_count > nts_pkg::MaxRecords) ? nts_pkg::MaxRecords : int'(rec_count);
    if (n == 0) begin
      r.status = nts_pkg::StatusEmpty;
      return r;
    end
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (rec_mem[mid] < target) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) best = n - 1;
    else if (lo == 0) best = 0;
    else if (abs_gap(rec_mem[lo-1], target) <= abs_gap(rec_mem[lo], target)) best = lo - 1;
    else best = lo;
    r.status = nts_pkg::StatusFound;
    r.nearest_index = nts_pkg::IdxW'(best);
    r.nearest_time = rec_mem[best];
    r.distance = abs_gap(rec_mem[best], target);
    r.exact_hit = (r.distance == '0);
    return r;
  endfunction

  task automatic check_field(input string name,
                             input logic [nts_pkg::TimeW-1:0] want, got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // request and result-stall driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_data <= '0;
      res_stall <= 1'b0;
    end else begin
      if (!req_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_data <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    nts_pkg::out_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
      rec_count = '0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_nearest.size() == 0) begin
          $error("result transfer with no search outstanding");
          fail_count++;
        end else begin
          want = expected_nearest.pop_front();
          check_field("status", want.status, res_data.status);
          check_field("nearest_index", want.nearest_index, res_data.nearest_index);
          check_field("nearest_time", want.nearest_time, res_data.nearest_time);
          check_field("distance", want.distance, res_data.distance);
          check_field("exact_hit", want.exact_hit, res_data.exact_hit);
        end
      end
      if (cfg_wr_en) rec_count = cfg_wr_data;
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        reqs_taken_cnt++;
        if (req_data.req_type == nts_pkg::ReqWrite) begin
          rec_mem[req_data.slot_index] = req_data.time_value;
        end else begin
          expected_nearest.push_back(nearest_of(req_data.time_value));
        end
      end
    end
  end

  task automatic push_item(input logic kind, input logic [nts_pkg::IdxW-1:0] slot,
                           input logic [nts_pkg::TimeW-1:0] value);
    nts_pkg::in_item_t it;
    it.req_type = kind;
    it.slot_index = slot;
    it.time_value = value;
    if (kind == nts_pkg::ReqWrite) begin
      gen_table[slot] = value;
      gen_written[slot] = 1'b1;
      while (filled < nts_pkg::MaxRecords && gen_written[filled]) filled++;
    end
    pending_reqs.push_back(it);
    reqs_queued++;
  endtask

  task automatic wait_idle();
    while (reqs_taken_cnt != reqs_queued || expected_nearest.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_count(input int c);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= nts_pkg::CountW'(c);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    table_len = (c > nts_pkg::MaxRecords) ? nts_pkg::MaxRecords : c;
  endtask

  // ascending records with random steps, duplicate-heavy some of the time
  task automatic load_table(input int lo_slot, input int hi_slot);
    logic [63:0] v, step_max;
    v = (lo_slot == 0) ? 64'($urandom_range(1000)) : 64'(gen_table[lo_slot-1]);
    step_max = (64'hFFFF_FFFF - v) / (hi_slot - lo_slot + 1);
    if ($urandom_range(3) == 0 && step_max > 3) step_max = 3;
    for (int s = lo_slot; s < hi_slot; s++) begin
      v += 64'($urandom()) % (step_max + 1);
      push_item(nts_pkg::ReqWrite, nts_pkg::IdxW'(s), v[nts_pkg::TimeW-1:0]);
    end
  endtask

  function automatic logic [nts_pkg::TimeW-1:0] pick_target();
    int k;
    logic [nts_pkg::TimeW-1:0] t;
    k = (table_len > 0) ? $urandom_range(table_len - 1) : 0;
    case ($urandom_range(7))
      0: t = gen_table[k];
      1: t = gen_table[k] + 1;
      2: t = gen_table[k] - 1;
      3: t = (k + 1 < table_len) ?
             nts_pkg::TimeW'((64'(gen_table[k]) + 64'(gen_table[k+1])) >> 1) : gen_table[k];
      4: t = '0;
      5: t = '1;
      default: t = $urandom();
    endcase
    return t;
  endfunction

  task automatic run_traffic(input int count);
    int s;
    logic [63:0] lo_v, hi_v, v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(59) == 0) wait_idle();
      if ($urandom_range(4) != 0) begin
        push_item(nts_pkg::ReqSearch, nts_pkg::IdxW'($urandom()), pick_target());
      end else begin
        s = $urandom_range(nts_pkg::MaxRecords - 1);
        lo_v = (s == 0 || !gen_written[s-1]) ? 64'd0 : 64'(gen_table[s-1]);
        hi_v = (s == nts_pkg::MaxRecords - 1 || !gen_written[s+1]) ? 64'hFFFF_FFFF
             : 64'(gen_table[s+1]);
        // mostly keep the table ordered, sometimes scramble it
        if ($urandom_range(7) == 0 || lo_v > hi_v) v = 64'($urandom());
        else v = lo_v + 64'($urandom()) % (hi_v - lo_v + 1);
        push_item(nts_pkg::ReqWrite, nts_pkg::IdxW'(s), v[nts_pkg::TimeW-1:0]);
      end
    end
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 72;
    // empty table
    push_item(nts_pkg::ReqSearch, '0, '0);
    push_item(nts_pkg::ReqSearch, '1, '1);
    push_item(nts_pkg::ReqWrite, 10'd0, 32'd0);
    push_item(nts_pkg::ReqWrite, 10'd1, 32'd10);
    push_item(nts_pkg::ReqWrite, 10'd2, 32'd20);
    push_item(nts_pkg::ReqWrite, 10'd3, 32'd20);
    push_item(nts_pkg::ReqWrite, 10'd4, 32'd40);
    push_item(nts_pkg::ReqWrite, 10'd5, 32'd100);
    push_item(nts_pkg::ReqWrite, 10'd6, 32'd1000);
    push_item(nts_pkg::ReqWrite, 10'd7, 32'hFFFF_FFFF);
    push_item(nts_pkg::ReqWrite, 10'd1023, 32'hA5A5_5A5A);
    set_count(1);
    push_item(nts_pkg::ReqSearch, '0, 32'd5);
    push_item(nts_pkg::ReqSearch, '0, 32'hFFFF_FFFF);
    set_count(8);
    push_item(nts_pkg::ReqSearch, '0, 32'd0);
    push_item(nts_pkg::ReqSearch, '0, 32'd20);
    push_item(nts_pkg::ReqSearch, '0, 32'd30);
    push_item(nts_pkg::ReqSearch, '0, 32'd550);
    push_item(nts_pkg::ReqSearch, '0, 32'd551);
    push_item(nts_pkg::ReqSearch, '0, 32'hFFFF_FFFF);
    push_item(nts_pkg::ReqSearch, '0, 32'hFFFF_FFFE);
    push_item(nts_pkg::ReqSearch, '0, 32'd41);

    wait_idle();
    load_table(0, 40);
    set_count(40);
    run_traffic(70);
    set_count(1);
    run_traffic(30);
    set_count(0);
    run_traffic(20);

    wait_idle();
    send_idle_pct = 72;
    recv_idle_pct = 20;
    n = $urandom_range(60, 120);
    load_table(0, n);
    set_count(n);
    run_traffic(60);
    set_count($urandom_range(2, n));
    run_traffic(40);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    if (filled < nts_pkg::MaxRecords) load_table(filled, nts_pkg::MaxRecords);
    set_count(nts_pkg::MaxRecords);
    run_traffic(50);
    set_count(2047);
    run_traffic(30);
    set_count(nts_pkg::MaxRecords - 1);
    run_traffic(20);
    set_count($urandom_range(nts_pkg::MaxRecords + 1, 2046));
    run_traffic(20);

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
